/* design/ubx_frame_parser_unit_defines.svh */
// ----------------------------------------------------------------------------
// ubx_frame_parser_unit_defines
// Assertion macros for the frame parser; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef UBX_FRAME_PARSER_UNIT_DEFINES_SVH
`define UBX_FRAME_PARSER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define UBXFP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ubx_frame_parser_unit: same-cycle check failed");
`define UBXFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ubx_frame_parser_unit: next-cycle check failed");
`else
`define UBXFP_ASSERT_SAME(label, ante, cons)
`define UBXFP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/ubxfp_pkg.sv */
// ----------------------------------------------------------------------------
// ubxfp_pkg
// Types and constants shared by the frame parser modules.
// ----------------------------------------------------------------------------
package ubxfp_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_MAX_LENGTH  = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;
  localparam logic [15:0] MAX_LENGTH_RST  = 16'd100;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_RESYNC = 2'd2;

  typedef enum logic [3:0] {
    ST_SYNC1   = 4'd0,
    ST_SYNC2   = 4'd1,
    ST_CLASS   = 4'd2,
    ST_ID      = 4'd3,
    ST_LENLO   = 4'd4,
    ST_LENHI   = 4'd5,
    ST_PAYLOAD = 4'd6,
    ST_CKA     = 4'd7,
    ST_CKB     = 4'd8
  } parse_step_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic        payload_strobe;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_good;
    logic        frame_bad;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic [15:0] good_frame_count;
    logic [15:0] bad_checksum_count;
    logic [15:0] non_sync_count;
    logic [15:0] byte_count;
  } result_t;

endpackage

/* design/ubxfp_if.sv */
// ----------------------------------------------------------------------------
// ubxfp interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface ubxfp_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface ubxfp_result_if;
  logic        valid;
  logic        ready;
  logic        payload_strobe;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic        frame_good;
  logic        frame_bad;
  logic [7:0]  frame_class;
  logic [7:0]  frame_id;
  logic [15:0] frame_length;
  logic [15:0] good_frame_count;
  logic [15:0] bad_checksum_count;
  logic [15:0] non_sync_count;
  logic [15:0] byte_count;

  modport source (
    output valid, output payload_strobe, output payload_byte, output payload_index,
    output frame_good, output frame_bad, output frame_class, output frame_id,
    output frame_length, output good_frame_count, output bad_checksum_count,
    output non_sync_count, output byte_count, input ready
  );
  modport sink (
    input valid, input payload_strobe, input payload_byte, input payload_index,
    input frame_good, input frame_bad, input frame_class, input frame_id,
    input frame_length, input good_frame_count, input bad_checksum_count,
    input non_sync_count, input byte_count, output ready
  );
endinterface

interface ubxfp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ubxfp_pkg::CfgIndexWidth-1:0] index;
  logic [ubxfp_pkg::CfgDataWidth-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

/* design/ubxfp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ubxfp_cfg_regs
// Sync byte and length limit registers.
// ----------------------------------------------------------------------------
module ubxfp_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [ubxfp_pkg::CfgIndexWidth-1:0] wr_index,
  input  logic [ubxfp_pkg::CfgDataWidth-1:0]  wr_data,
  output ubxfp_pkg::cfg_t                     cfg
);

  ubxfp_pkg::cfg_t cfg_r;
  ubxfp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        ubxfp_pkg::CFG_SYNC_FIRST:  cfg_nxt.sync_first  = wr_data[7:0];
        ubxfp_pkg::CFG_SYNC_SECOND: cfg_nxt.sync_second = wr_data[7:0];
        ubxfp_pkg::CFG_MAX_LENGTH:  cfg_nxt.max_length  = wr_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= ubxfp_pkg::SYNC_FIRST_RST;
      cfg_r.sync_second <= ubxfp_pkg::SYNC_SECOND_RST;
      cfg_r.max_length  <= ubxfp_pkg::MAX_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/ubxfp_in_reg.sv */
// ----------------------------------------------------------------------------
// ubxfp_in_reg
// Input register stage; holds one item until the parser steps on it.
// ----------------------------------------------------------------------------
module ubxfp_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ubxfp_pkg::item_t in_item,
  input  logic             take,
  output logic             valid,
  output ubxfp_pkg::item_t item
);

  logic             valid_r;
  logic             valid_nxt;
  ubxfp_pkg::item_t item_r;
  logic             load;

  assign in_ready  = !valid_r || take;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

/* design/ubxfp_parse_core.sv */
// ----------------------------------------------------------------------------
// ubxfp_parse_core
// Frame state machine, Fletcher-8 sums, held header fields and counters.
// ----------------------------------------------------------------------------
module ubxfp_parse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  ubxfp_pkg::item_t   item,
  input  ubxfp_pkg::cfg_t    cfg,
  output ubxfp_pkg::result_t result
);

  ubxfp_pkg::parse_step_t step_r, step_nxt;
  logic [7:0]  held_class_r, held_class_nxt;
  logic [7:0]  held_id_r, held_id_nxt;
  logic [15:0] held_length_r, held_length_nxt;
  logic [15:0] byte_position_r, byte_position_nxt;
  logic [7:0]  sum_first_r, sum_first_nxt;
  logic [7:0]  sum_second_r, sum_second_nxt;
  logic [7:0]  check_a_r, check_a_nxt;
  logic [15:0] good_frames_r, good_frames_nxt;
  logic [15:0] bad_sums_r, bad_sums_nxt;
  logic [15:0] stray_bytes_r, stray_bytes_nxt;
  logic [15:0] bytes_seen_r, bytes_seen_nxt;

  logic [7:0]  b;
  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [15:0] len_full;
  logic [16:0] pos_inc;
  logic        strobe;
  logic [7:0]  pbyte;
  logic [15:0] pindex;
  logic        good;
  logic        bad;

  assign b         = item.rx_byte;
  assign sum_a_add = sum_first_r + b;
  assign sum_b_add = sum_second_r + sum_a_add;
  assign len_full  = {b, held_length_r[7:0]};
  assign pos_inc   = {1'b0, byte_position_r} + 17'd1;

  always_comb begin
    step_nxt          = step_r;
    held_class_nxt    = held_class_r;
    held_id_nxt       = held_id_r;
    held_length_nxt   = held_length_r;
    byte_position_nxt = byte_position_r;
    sum_first_nxt     = sum_first_r;
    sum_second_nxt    = sum_second_r;
    check_a_nxt       = check_a_r;
    good_frames_nxt   = good_frames_r;
    bad_sums_nxt      = bad_sums_r;
    stray_bytes_nxt   = stray_bytes_r;
    bytes_seen_nxt    = bytes_seen_r;
    strobe            = 1'b0;
    pbyte             = 8'd0;
    pindex            = 16'd0;
    good              = 1'b0;
    bad               = 1'b0;

    unique case (item.kind)
      ubxfp_pkg::KIND_CLEAR: begin
        good_frames_nxt = 16'd0;
        bad_sums_nxt    = 16'd0;
        stray_bytes_nxt = 16'd0;
        bytes_seen_nxt  = 16'd0;
      end
      ubxfp_pkg::KIND_RESYNC: begin
        step_nxt = ubxfp_pkg::ST_SYNC1;
      end
      ubxfp_pkg::KIND_BYTE: begin
        bytes_seen_nxt = bytes_seen_r + 16'd1;
        unique case (step_r)
          ubxfp_pkg::ST_SYNC2: begin
            step_nxt = (b == cfg.sync_second) ? ubxfp_pkg::ST_CLASS : ubxfp_pkg::ST_SYNC1;
          end
          ubxfp_pkg::ST_CLASS: begin
            held_class_nxt = b;
            sum_first_nxt  = b;
            sum_second_nxt = b;
            step_nxt       = ubxfp_pkg::ST_ID;
          end
          ubxfp_pkg::ST_ID: begin
            held_id_nxt    = b;
            sum_first_nxt  = sum_a_add;
            sum_second_nxt = sum_b_add;
            step_nxt       = ubxfp_pkg::ST_LENLO;
          end
          ubxfp_pkg::ST_LENLO: begin
            held_length_nxt = {8'd0, b};
            sum_first_nxt   = sum_a_add;
            sum_second_nxt  = sum_b_add;
            step_nxt        = ubxfp_pkg::ST_LENHI;
          end
          ubxfp_pkg::ST_LENHI: begin
            held_length_nxt   = len_full;
            sum_first_nxt     = sum_a_add;
            sum_second_nxt    = sum_b_add;
            byte_position_nxt = 16'd0;
            if (len_full > cfg.max_length) begin
              step_nxt = ubxfp_pkg::ST_SYNC1;
            end else if (len_full == 16'd0) begin
              step_nxt = ubxfp_pkg::ST_CKA;
            end else begin
              step_nxt = ubxfp_pkg::ST_PAYLOAD;
            end
          end
          ubxfp_pkg::ST_PAYLOAD: begin
            strobe            = 1'b1;
            pbyte             = b;
            pindex            = byte_position_r;
            sum_first_nxt     = sum_a_add;
            sum_second_nxt    = sum_b_add;
            byte_position_nxt = pos_inc[15:0];
            if (pos_inc >= {1'b0, held_length_r}) begin
              step_nxt = ubxfp_pkg::ST_CKA;
            end
          end
          ubxfp_pkg::ST_CKA: begin
            check_a_nxt = b;
            step_nxt    = ubxfp_pkg::ST_CKB;
          end
          ubxfp_pkg::ST_CKB: begin
            step_nxt = ubxfp_pkg::ST_SYNC1;
            if (check_a_r != sum_first_r || b != sum_second_r) begin
              bad          = 1'b1;
              bad_sums_nxt = bad_sums_r + 16'd1;
            end else begin
              good            = 1'b1;
              good_frames_nxt = good_frames_r + 16'd1;
            end
          end
          default: begin
            if (b == cfg.sync_first) begin
              step_nxt = ubxfp_pkg::ST_SYNC2;
            end else begin
              step_nxt        = ubxfp_pkg::ST_SYNC1;
              stray_bytes_nxt = stray_bytes_r + 16'd1;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r          <= ubxfp_pkg::ST_SYNC1;
      held_class_r    <= 8'd0;
      held_id_r       <= 8'd0;
      held_length_r   <= 16'd0;
      byte_position_r <= 16'd0;
      sum_first_r     <= 8'd0;
      sum_second_r    <= 8'd0;
      check_a_r       <= 8'd0;
      good_frames_r   <= 16'd0;
      bad_sums_r      <= 16'd0;
      stray_bytes_r   <= 16'd0;
      bytes_seen_r    <= 16'd0;
    end else if (step) begin
      step_r          <= step_nxt;
      held_class_r    <= held_class_nxt;
      held_id_r       <= held_id_nxt;
      held_length_r   <= held_length_nxt;
      byte_position_r <= byte_position_nxt;
      sum_first_r     <= sum_first_nxt;
      sum_second_r    <= sum_second_nxt;
      check_a_r       <= check_a_nxt;
      good_frames_r   <= good_frames_nxt;
      bad_sums_r      <= bad_sums_nxt;
      stray_bytes_r   <= stray_bytes_nxt;
      bytes_seen_r    <= bytes_seen_nxt;
    end
  end

  always_comb begin
    result.payload_strobe     = strobe;
    result.payload_byte       = pbyte;
    result.payload_index      = pindex;
    result.frame_good         = good;
    result.frame_bad          = bad;
    result.frame_class        = held_class_nxt;
    result.frame_id           = held_id_nxt;
    result.frame_length       = held_length_nxt;
    result.good_frame_count   = good_frames_nxt;
    result.bad_checksum_count = bad_sums_nxt;
    result.non_sync_count     = stray_bytes_nxt;
    result.byte_count         = bytes_seen_nxt;
  end

endmodule

/* design/ubxfp_out_reg.sv */
// ----------------------------------------------------------------------------
// ubxfp_out_reg
// Result register; holds one result until the sink takes the transfer.
// ----------------------------------------------------------------------------
module ubxfp_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ubxfp_pkg::result_t result_d,
  input  logic               out_ready,
  output logic               out_valid,
  output ubxfp_pkg::result_t result_q,
  output logic               free
);

  logic               valid_r;
  logic               valid_nxt;
  ubxfp_pkg::result_t result_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_d;
    end
  end

  assign out_valid = valid_r;
  assign result_q  = result_r;

endmodule

/* design/ubx_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// ubx_frame_parser_unit
// Byte-stream parser for sync-framed binary messages with Fletcher-8 check.
// ----------------------------------------------------------------------------
// One item per clock is accepted, as long as the result side keeps ready
// high, and one result per item comes out through the input register, then
// the result register. The whole per-byte update of the frame state, the
// check sums and the counters is combinational logic between those two
// registers. Register writes take effect in the cycle after their transfer
// and are expected only while no item is in flight.
`include "ubx_frame_parser_unit_defines.svh"

module ubx_frame_parser_unit (
  input  logic           clk,
  input  logic           rst_n,
  ubxfp_item_if.sink     in_chan,
  ubxfp_result_if.source out_chan,
  ubxfp_cfg_if.sink      cfg_chan
);

  ubxfp_pkg::cfg_t    cfg;
  ubxfp_pkg::item_t   in_item;
  ubxfp_pkg::item_t   s1_item;
  ubxfp_pkg::result_t core_result;
  ubxfp_pkg::result_t out_result;
  logic               s1_valid;
  logic               free;
  logic               step;
  logic               out_valid;
  logic               in_ready;

  assign cfg_chan.ready = 1'b1;

  ubxfp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.wdata),
    .cfg      (cfg)
  );

  assign in_item.kind    = in_chan.kind;
  assign in_item.rx_byte = in_chan.rx_byte;
  assign in_chan.ready   = in_ready;

  ubxfp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (step),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  assign step = s1_valid && free;

  ubxfp_parse_core u_parse_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s1_item),
    .cfg    (cfg),
    .result (core_result)
  );

  ubxfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .result_d  (core_result),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .result_q  (out_result),
    .free      (free)
  );

  assign out_chan.valid              = out_valid;
  assign out_chan.payload_strobe     = out_result.payload_strobe;
  assign out_chan.payload_byte       = out_result.payload_byte;
  assign out_chan.payload_index      = out_result.payload_index;
  assign out_chan.frame_good         = out_result.frame_good;
  assign out_chan.frame_bad          = out_result.frame_bad;
  assign out_chan.frame_class        = out_result.frame_class;
  assign out_chan.frame_id           = out_result.frame_id;
  assign out_chan.frame_length       = out_result.frame_length;
  assign out_chan.good_frame_count   = out_result.good_frame_count;
  assign out_chan.bad_checksum_count = out_result.bad_checksum_count;
  assign out_chan.non_sync_count     = out_result.non_sync_count;
  assign out_chan.byte_count         = out_result.byte_count;

  `UBXFP_ASSERT_SAME(a_good_bad_excl, out_valid, !(out_result.frame_good && out_result.frame_bad))
  `UBXFP_ASSERT_SAME(a_index_in_len, out_valid && out_result.payload_strobe, out_result.payload_index < out_result.frame_length)
  `UBXFP_ASSERT_NEXT(a_step_fills_out, step, out_valid)
  `UBXFP_ASSERT_NEXT(a_stall_keeps_item, s1_valid && !free, s1_valid)

endmodule

/* sim/frame_check_pkg.sv */
// ----------------------------------------------------------------------------
// frame_check_pkg
// Scoreboard for the frame parser: tracks parser state, sums and counters
// for every accepted item and checks each result in order against it.
// ----------------------------------------------------------------------------
package frame_check_pkg;
  import ubxfp_pkg::*;

  class frame_scoreboard;
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_length;

    parse_step_t parse_step;
    logic [7:0]  held_class;
    logic [7:0]  held_id;
    logic [15:0] held_length;
    logic [15:0] position;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  check_a;
    logic [15:0] good_frames;
    logic [15:0] bad_sums;
    logic [15:0] stray_bytes;
    logic [15:0] bytes_seen;

    result_t expected_results[$];
    int      errors;

    function new();
      sync_first  = SYNC_FIRST_RST;
      sync_second = SYNC_SECOND_RST;
      max_length  = MAX_LENGTH_RST;
      parse_step  = ST_SYNC1;
      held_class  = '0;
      held_id     = '0;
      held_length = '0;
      position    = '0;
      sum_a       = '0;
      sum_b       = '0;
      check_a     = '0;
      good_frames = '0;
      bad_sums    = '0;
      stray_bytes = '0;
      bytes_seen  = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
      case (idx)
        CFG_SYNC_FIRST:  sync_first  = val[7:0];
        CFG_SYNC_SECOND: sync_second = val[7:0];
        CFG_MAX_LENGTH:  max_length  = val;
        default: ;
      endcase
    endfunction

    function void add_sum(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    function void note_item(item_t it);
      result_t     r;
      logic [7:0]  b;
      logic [16:0] next_pos;
      r = '0;
      b = it.rx_byte;
      case (it.kind)
        KIND_CLEAR: begin
          good_frames = '0;
          bad_sums    = '0;
          stray_bytes = '0;
          bytes_seen  = '0;
        end
        KIND_RESYNC: parse_step = ST_SYNC1;
        KIND_BYTE: begin
          bytes_seen = bytes_seen + 16'd1;
          case (parse_step)
            ST_SYNC2: begin
              // mismatch drops back to hunting without a second look
              if (b == sync_second) parse_step = ST_CLASS;
              else parse_step = ST_SYNC1;
            end
            ST_CLASS: begin
              held_class = b;
              sum_a      = b;
              sum_b      = b;
              parse_step = ST_ID;
            end
            ST_ID: begin
              held_id = b;
              add_sum(b);
              parse_step = ST_LENLO;
            end
            ST_LENLO: begin
              held_length = {8'h00, b};
              add_sum(b);
              parse_step = ST_LENHI;
            end
            ST_LENHI: begin
              held_length[15:8] = b;
              add_sum(b);
              position = '0;
              if (held_length > max_length) parse_step = ST_SYNC1;
              else if (held_length == 16'd0) parse_step = ST_CKA;
              else parse_step = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
              r.payload_strobe = 1'b1;
              r.payload_byte   = b;
              r.payload_index  = position;
              add_sum(b);
              next_pos = {1'b0, position} + 17'd1;
              if (next_pos >= {1'b0, held_length}) parse_step = ST_CKA;
              position = position + 16'd1;
            end
            ST_CKA: begin
              check_a    = b;
              parse_step = ST_CKB;
            end
            ST_CKB: begin
              parse_step = ST_SYNC1;
              if (check_a != sum_a || b != sum_b) begin
                r.frame_bad = 1'b1;
                bad_sums    = bad_sums + 16'd1;
              end else begin
                r.frame_good = 1'b1;
                good_frames  = good_frames + 16'd1;
              end
            end
            default: begin
              if (b == sync_first) begin
                parse_step = ST_SYNC2;
              end else begin
                parse_step  = ST_SYNC1;
                stray_bytes = stray_bytes + 16'd1;
              end
            end
          endcase
        end
        default: ;
      endcase
      r.frame_class        = held_class;
      r.frame_id           = held_id;
      r.frame_length       = held_length;
      r.good_frame_count   = good_frames;
      r.bad_checksum_count = bad_sums;
      r.non_sync_count     = stray_bytes;
      r.byte_count         = bytes_seen;
      expected_results.push_back(r);
    endfunction

    function int pending_count();
      return expected_results.size();
    endfunction

    function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
      if (act !== exp) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_results.size() == 0) begin
        $error("result transfer with no item outstanding");
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      compare_field("payload_strobe", 16'(exp.payload_strobe), 16'(got.payload_strobe));
      compare_field("payload_byte", 16'(exp.payload_byte), 16'(got.payload_byte));
      compare_field("payload_index", exp.payload_index, got.payload_index);
      compare_field("frame_good", 16'(exp.frame_good), 16'(got.frame_good));
      compare_field("frame_bad", 16'(exp.frame_bad), 16'(got.frame_bad));
      compare_field("frame_class", 16'(exp.frame_class), 16'(got.frame_class));
      compare_field("frame_id", 16'(exp.frame_id), 16'(got.frame_id));
      compare_field("frame_length", exp.frame_length, got.frame_length);
      compare_field("good_frame_count", exp.good_frame_count, got.good_frame_count);
      compare_field("bad_checksum_count", exp.bad_checksum_count, got.bad_checksum_count);
      compare_field("non_sync_count", exp.non_sync_count, got.non_sync_count);
      compare_field("byte_count", exp.byte_count, got.byte_count);
    endfunction
  endclass

endpackage

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Frame parser testbench: directed sync, length and command cases, then
// random frames, broken frames and noise under several sync and length
// settings, with bursty input, random output stalls and a long output
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ubxfp_pkg::*;
  import frame_check_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned FloodItems = 100;
  localparam logic [1:0] KindUnused = 2'd3;
  localparam logic [CfgIndexWidth-1:0] CfgUnused = 2'd3;

  logic clk;
  logic rst_n;

  ubxfp_item_if   item_if ();
  ubxfp_result_if result_if ();
  ubxfp_cfg_if    cfg_if ();

  frame_scoreboard sb = new();

  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned cycles = 0;
  int unsigned flood_id;
  int unsigned served_flood = 0;
  bit          flood;

  ubx_frame_parser_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (item_if),
    .out_chan (result_if),
    .cfg_chan (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("ubx_frame_parser_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && result_if.valid && result_if.ready) begin
      got.payload_strobe     = result_if.payload_strobe;
      got.payload_byte       = result_if.payload_byte;
      got.payload_index      = result_if.payload_index;
      got.frame_good         = result_if.frame_good;
      got.frame_bad          = result_if.frame_bad;
      got.frame_class        = result_if.frame_class;
      got.frame_id           = result_if.frame_id;
      got.frame_length       = result_if.frame_length;
      got.good_frame_count   = result_if.good_frame_count;
      got.bad_checksum_count = result_if.bad_checksum_count;
      got.non_sync_count     = result_if.non_sync_count;
      got.byte_count         = result_if.byte_count;
      sb.check_result(got);
    end
  end

  // result side: stall patterns, plus one long hold-off per flood
  initial begin
    int unsigned mode;
    int unsigned span;
    result_if.ready = 1'b0;
    forever begin
      if (flood && served_flood != flood_id) begin
        served_flood = flood_id;
        repeat (HoldCycles) begin
          @(negedge clk);
          result_if.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 24);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: result_if.ready <= 1'b1;
          1: result_if.ready <= 1'($urandom_range(0, 1));
          2: result_if.ready <= ($urandom_range(0, 3) == 0);
          default: result_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [7:0] b);
    int unsigned gap;
    item_t       it;
    if (!flood && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        item_if.valid   <= 1'b0;
        item_if.kind    <= 2'($urandom_range(0, 3));
        item_if.rx_byte <= 8'($urandom_range(0, 255));
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    item_if.valid   <= 1'b1;
    item_if.kind    <= kind;
    item_if.rx_byte <= b;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    it.kind    = kind;
    it.rx_byte = b;
    sb.note_item(it);
    items_sent++;
    if (burst_left != 0) burst_left--;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(KIND_BYTE, b);
  endtask

  // full frame, optionally with bad check bytes, cut short after cut bytes
  task automatic send_frame(logic [7:0] cls, logic [7:0] id, logic [15:0] len,
                            bit corrupt, int unsigned cut);
    logic [7:0]  frame[$];
    logic [7:0]  a;
    logic [7:0]  bb;
    int unsigned sel;
    frame = {sb.sync_first, sb.sync_second, cls, id, len[7:0], len[15:8]};
    for (int unsigned i = 0; i < len; i++) frame.push_back(8'($urandom_range(0, 255)));
    a  = '0;
    bb = '0;
    for (int i = 2; i < frame.size(); i++) begin
      a  = a + frame[i];
      bb = bb + a;
    end
    if (corrupt) begin
      sel = $urandom_range(0, 2);
      if (sel != 1) a  = a ^ (8'd1 << $urandom_range(0, 7));
      if (sel != 0) bb = bb ^ (8'd1 << $urandom_range(0, 7));
    end
    frame.push_back(a);
    frame.push_back(bb);
    for (int i = 0; i < frame.size() && i < cut; i++) begin
      // commands that must not disturb parsing
      if ($urandom_range(0, 49) == 0)
        send_item($urandom_range(0, 1) ? KIND_CLEAR : KindUnused, 8'($urandom_range(0, 255)));
      send_byte(frame[i]);
    end
  endtask

  function automatic logic [15:0] pick_length();
    int unsigned lim;
    if ($urandom_range(0, 15) == 0) return (sb.max_length <= 100) ? sb.max_length : 16'd64;
    lim = (sb.max_length < 12) ? sb.max_length : 12;
    return 16'($urandom_range(0, lim));
  endfunction

  task automatic random_traffic(int unsigned target);
    int unsigned choice;
    int unsigned total;
    int unsigned n;
    logic [15:0] len;
    while (items_sent < target) begin
      choice = $urandom_range(0, 99);
      if (choice < 62) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_length(),
                   ($urandom_range(0, 3) == 0), 32'hFFFF_FFFF);
      end else if (choice < 74) begin
        len   = pick_length();
        total = 8 + len;
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, 1'b0,
                   $urandom_range(1, total - 1));
        if ($urandom_range(0, 9) < 7) send_item(KIND_RESYNC, 8'($urandom_range(0, 255)));
      end else if (choice < 86) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 9) < 3) send_byte(sb.sync_first);
          else send_byte(8'($urandom_range(0, 255)));
        end
      end else if (choice < 92) begin
        send_byte(sb.sync_first);
        send_byte(sb.sync_second);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        if (sb.max_length != 16'hFFFF && $urandom_range(0, 1)) begin
          len = 16'($urandom_range(int'(sb.max_length) + 1, 65535));
        end else begin
          // accepted long length, abandoned by a resync unless it is zero
          len = 16'($urandom_range(int'(sb.max_length) / 2, int'(sb.max_length)));
        end
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (len <= sb.max_length && len != 16'd0) begin
          n = $urandom_range(1, 5);
          repeat (n) send_byte(8'($urandom_range(0, 255)));
          send_item(KIND_RESYNC, 8'($urandom_range(0, 255)));
        end
      end else begin
        n = $urandom_range(0, 2);
        send_item((n == 0) ? KIND_CLEAR : (n == 1) ? KIND_RESYNC : KindUnused,
                  8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic flood_traffic();
    int unsigned stop_at;
    flood   = 1'b1;
    flood_id++;
    stop_at = items_sent + FloodItems;
    while (items_sent < stop_at)
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_length(),
                 ($urandom_range(0, 3) == 0), 32'hFFFF_FFFF);
    flood = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    item_if.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cfg_if.wdata <= 16'($urandom_range(0, 65535));
  endtask

  task automatic configure(logic [7:0] sf, logic [7:0] ss, logic [15:0] ml);
    write_reg(CFG_SYNC_FIRST, {8'($urandom_range(0, 255)), sf});
    write_reg(CFG_SYNC_SECOND, {8'($urandom_range(0, 255)), ss});
    write_reg(CFG_MAX_LENGTH, ml);
    if ($urandom_range(0, 1)) write_reg(CfgUnused, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    rst_n           = 1'b0;
    item_if.valid   = 1'b0;
    item_if.kind    = KIND_BYTE;
    item_if.rx_byte = 8'h00;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_SYNC_FIRST;
    cfg_if.wdata    = 16'h0000;
    items_sent      = 0;
    burst_left      = 0;
    flood           = 1'b0;
    flood_id        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, at reset register values
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_FIRST_RST);
    send_frame(8'hFF, 8'h00, 16'd0, 1'b0, 32'hFFFF_FFFF);
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_SECOND_RST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'(MAX_LENGTH_RST + 16'd1));
    send_byte(8'h00);
    send_item(KindUnused, 8'hA5);
    send_item(KIND_CLEAR, 8'h5A);
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_SECOND_RST);
    send_item(KIND_RESYNC, 8'hFF);

    configure(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LENGTH_RST);
    write_reg(CfgUnused, 16'hFFFF);
    random_traffic(items_sent + 170);
    flood_traffic();
    random_traffic(items_sent + 170);

    configure(8'h00, 8'hFF, 16'h0000);
    random_traffic(items_sent + 170);

    configure(8'hFF, 8'h00, 16'hFFFF);
    random_traffic(items_sent + 100);
    flood_traffic();
    random_traffic(items_sent + 100);

    repeat (3) begin
      configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 30)));
      random_traffic(items_sent + 75);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("ubx_frame_parser_unit test passed");
    end else begin
      if (sb.pending_count() != 0) $error("%0d results never arrived", sb.pending_count());
      $display("ubx_frame_parser_unit test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/ubxfp_pkg.sv
design/ubxfp_if.sv
design/ubxfp_cfg_regs.sv
design/ubxfp_in_reg.sv
design/ubxfp_parse_core.sv
design/ubxfp_out_reg.sv
design/ubx_frame_parser_unit.sv
sim/frame_check_pkg.sv
sim/tb_top.sv
